// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked only while the reset is released.
`define TLAS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked at every clock edge, reset included.
`define TLAS_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TLAS_ASSERT(name, clk, rst_n, prop, msg)
`define TLAS_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

// ===== src/tlas_pkg.sv =====
// ----------------------------------------------------------------------------
// Arm sweep package
// Item types, register indexes and the constant sine tables of the block.
// ----------------------------------------------------------------------------
package tlas_pkg;

  // Register indexes on the configuration port.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [0:0] REG_TARGET_HEIGHT = 1'b0;
  localparam logic [0:0] REG_INTERVAL      = 1'b1;

  localparam int unsigned CFG_DATA_W = 16;

  // Sweep limits in degrees.
  localparam logic [7:0] BOTTOM_MIN  = 8'd70;
  localparam logic [7:0] BOTTOM_MAX  = 8'd170;
  localparam logic [7:0] ROT_MIN     = 8'd40;
  localparam logic [7:0] ROT_MAX     = 8'd140;
  localparam logic [7:0] BOTTOM_RST  = 8'd90;
  localparam logic [7:0] ROT_RST     = 8'd90;
  localparam logic [7:0] BETA_CENTER = 8'd135;
  localparam logic [7:0] BAND_SPLIT  = 8'd135;
  localparam logic [8:0] ANGLE_MAX   = 9'd180;
  localparam logic [8:0] BETA_FLOOR  = 9'd40;
  localparam logic [8:0] BAND_TOP    = 9'd310;

  localparam logic [15:0] INTERVAL_RST = 16'd50;
  localparam logic [12:0] HEIGHT_RST   = 13'd1280;

  // Fixed point constants, Q14.
  localparam int          SIX_HALF_Q14 = 106496;
  localparam logic [17:0] MAG_OVER     = 18'd163845;  // mag at which |s| exceeds one
  localparam logic [17:0] ROUND_HALF   = 18'd5;
  localparam logic [17:0] RECIP_TEN    = 18'd209716;  // ceil(2^21 / 10)
  localparam int unsigned RECIP_SHIFT  = 21;

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam int unsigned     NUM_DEG = 90;

  // Input and result items.
  typedef struct packed {
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0] bottom_angle;
    logic [7:0] top_angle;
    logic [7:0] rotator_angle;
  } out_item_t;

  // One stepped position pair handed from the front to the back.
  typedef struct packed {
    logic [7:0] bottom;
    logic [7:0] rotator;
  } step_t;

  // Queue status seen by the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef logic signed [18:0] s8_tab_t [256];
  typedef logic [14:0]        thr_tab_t [1:NUM_DEG];

  // sin(i * 0.5 deg) in Q14 from a Q30 Taylor series; elaboration only.
  // Each term divides the previous one by (2n)(2n + 1) for n = 1..7.
  function automatic logic [14:0] sin_half(int unsigned i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    int unsigned     ii;
    ii   = (i > 180) ? 180 : i;
    x    = (longint'(ii) * PI_Q30 + 64'd180) / 64'd360;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - longint'(term);
    if (sum < 0) sum = 0;
    return 15'((longint'(sum) + 64'd32768) >> 16);
  endfunction

  // Signed sine of a whole degree, Q14.
  function automatic int sin_deg(int d);
    int r;
    r = ((d % 360) + 360) % 360;
    if (r <= 90) return int'(sin_half(2 * r));
    if (r <= 180) return int'(sin_half(2 * (180 - r)));
    if (r <= 270) return -int'(sin_half(2 * (r - 180)));
    return -int'(sin_half(2 * (360 - r)));
  endfunction

  // Eight times sin(195 - a) for every bottom angle a.
  function automatic s8_tab_t build_s8();
    s8_tab_t tab;
    for (int a = 0; a < 256; a++) tab[a] = 19'(8 * sin_deg(195 - a));
    return tab;
  endfunction

  // Rounding thresholds of the arcsine: sin(k - 0.5 deg).
  function automatic thr_tab_t build_thr();
    thr_tab_t tab;
    for (int k = 1; k <= NUM_DEG; k++) tab[k] = sin_half(2 * k - 1);
    return tab;
  endfunction

  localparam s8_tab_t  S8_TAB  = build_s8();
  localparam thr_tab_t THR_TAB = build_thr();

endpackage

// ===== src/tlas_stream_if.sv =====
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one item of a given type.
// ----------------------------------------------------------------------------
interface tlas_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/tlas_front.sv =====
// ----------------------------------------------------------------------------
// Arm sweep front end
// Accepts time items, decides whether a step is due and advances the sweep.
// ----------------------------------------------------------------------------
module tlas_front import tlas_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [31:0] now_ms_i,
  output logic        in_ready_o,
  input  logic [15:0] interval_i,
  input  logic        fifo_full_i,
  output logic        push_o,
  output step_t       push_data_o
);

  logic [31:0] last_q, last_d;
  logic [7:0]  bottom_q, bottom_d;
  logic [7:0]  rot_q, rot_d;
  logic        bottom_down_q, bottom_down_d;
  logic        rot_down_q, rot_down_d;
  logic [31:0] elapsed;
  logic        due;
  logic        accept;

  // An item is taken whenever the queue has room for a possible step.
  assign in_ready_o = ~fifo_full_i;
  assign accept     = in_valid_i & ~fifo_full_i;
  assign elapsed    = now_ms_i - last_q;
  assign due        = elapsed >= {16'd0, interval_i};

  // Next positions and direction flips at the band ends.
  always_comb begin
    last_d        = last_q;
    bottom_d      = bottom_q;
    rot_d         = rot_q;
    bottom_down_d = bottom_down_q;
    rot_down_d    = rot_down_q;
    if (accept && due) begin
      last_d   = now_ms_i;
      bottom_d = bottom_down_q ? bottom_q - 8'd1 : bottom_q + 8'd1;
      rot_d    = rot_down_q ? rot_q - 8'd1 : rot_q + 8'd1;
      if (bottom_d >= BOTTOM_MAX || bottom_d <= BOTTOM_MIN) bottom_down_d = ~bottom_down_q;
      if (rot_d >= ROT_MAX || rot_d <= ROT_MIN) rot_down_d = ~rot_down_q;
    end
  end

  assign push_o              = accept & due;
  assign push_data_o.bottom  = bottom_d;
  assign push_data_o.rotator = rot_d;

  // Sweep state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q        <= '0;
      bottom_q      <= BOTTOM_RST;
      rot_q         <= ROT_RST;
      bottom_down_q <= 1'b0;
      rot_down_q    <= 1'b0;
    end else begin
      last_q        <= last_d;
      bottom_q      <= bottom_d;
      rot_q         <= rot_d;
      bottom_down_q <= bottom_down_d;
      rot_down_q    <= rot_down_d;
    end
  end

endmodule

// ===== src/tlas_fifo.sv =====
// ----------------------------------------------------------------------------
// Step queue
// Small register queue that decouples the front end from the solver.
// ----------------------------------------------------------------------------
module tlas_fifo import tlas_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  step_t      push_data_i,
  input  logic       pop_i,
  output step_t      head_o,
  output fifo_stat_t stat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  step_t             mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d;
  logic [PTR_W-1:0]  rd_q, rd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & ~stat_o.empty;
  assign head_o       = mem_q[rd_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    if (do_pop) rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CNT_W'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule

// ===== src/tlas_back.sv =====
// ----------------------------------------------------------------------------
// Height solver
// Pipeline from stepped positions to the limited top angle and the result.
// ----------------------------------------------------------------------------
module tlas_back import tlas_pkg::*; #(
  parameter int unsigned HEIGHT_FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [12:0] target_height_i,
  input  logic        head_valid_i,
  input  step_t       head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);

  localparam int unsigned SHIFT_W = 14 - HEIGHT_FRAC_BITS;
  localparam int unsigned H_W     = 13 + SHIFT_W;
  localparam int unsigned NUM_W   = ((H_W + 1 > 19) ? H_W + 1 : 19) + 1;

  logic                    en;
  logic signed [NUM_W-1:0] h_ext;
  logic signed [NUM_W-1:0] num_d;
  logic [NUM_W-1:0]        mag;

  // Stage 1: numerator.
  logic                    s1_valid_q;
  step_t                   s1_pos_q;
  logic signed [NUM_W-1:0] s1_num_q;
  // Stage 2: magnitude plus rounding half, range check.
  logic                    s2_valid_q;
  step_t                   s2_pos_q;
  logic                    s2_neg_q;
  logic                    s2_over_q;
  logic [17:0]             s2_x_q;
  logic [17:0]             s2_x_d;
  // Stage 3: divided magnitude.
  logic                    s3_valid_q;
  step_t                   s3_pos_q;
  logic                    s3_neg_q;
  logic                    s3_over_q;
  logic [14:0]             s3_smag_q;
  logic [35:0]             prod;
  // Stage 4: arcsine thermometer.
  logic                    s4_valid_q;
  step_t                   s4_pos_q;
  logic                    s4_neg_q;
  logic                    s4_over_q;
  logic [NUM_DEG:1]        s4_therm_q;
  logic [NUM_DEG:1]        therm_d;
  // Output register.
  logic                    out_valid_q;
  out_item_t               out_q;

  logic [6:0] deg;
  logic [7:0] beta;
  logic [8:0] lo;
  logic [8:0] hi;
  logic [8:0] beta9;
  logic [7:0] top_d;

  // The whole pipe moves unless a finished result is held.
  assign en    = ~out_valid_q | out_ready_i;
  assign pop_o = en & head_valid_i;

  assign h_ext = $signed(NUM_W'({target_height_i, {SHIFT_W{1'b0}}}));
  assign num_d = h_ext - NUM_W'(SIX_HALF_Q14) - NUM_W'(S8_TAB[head_i.bottom]);

  // Magnitude and the rounding offset ahead of the divide by ten.
  assign mag    = s1_num_q[NUM_W-1] ? NUM_W'(-s1_num_q) : NUM_W'(s1_num_q);
  assign s2_x_d = 18'(mag) + ROUND_HALF;

  assign prod = s2_x_q * RECIP_TEN;

  // Thresholds of the arcsine rounding.
  always_comb begin
    for (int k = 1; k <= NUM_DEG; k++) therm_d[k] = (s3_smag_q >= THR_TAB[k]);
  end

  // Degree, center offset and the band limits. The thresholds rise with k,
  // so the set bits form a prefix and the highest one gives the degree.
  always_comb begin
    deg = '0;
    for (int k = 1; k <= NUM_DEG; k++) begin
      if (s4_therm_q[k]) deg = 7'(k);
    end
    beta = s4_neg_q ? BETA_CENTER - 8'(deg) : BETA_CENTER + 8'(deg);
    if (s4_pos_q.bottom <= BAND_SPLIT) begin
      lo = ANGLE_MAX - 9'(s4_pos_q.bottom);
      hi = ANGLE_MAX;
    end else begin
      lo = BETA_FLOOR;
      hi = BAND_TOP - 9'(s4_pos_q.bottom);
    end
    beta9 = 9'(beta);
    if (beta9 < lo) beta9 = lo;
    else if (beta9 > hi) beta9 = hi;
    top_d = beta9[7:0];
  end

  // Stage valid bits and the output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= head_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q & ~s4_over_q;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pos_q               <= head_i;
      s1_num_q               <= num_d;
      s2_pos_q               <= s1_pos_q;
      s2_neg_q               <= s1_num_q[NUM_W-1];
      s2_over_q              <= (mag >= NUM_W'(MAG_OVER));
      s2_x_q                 <= s2_x_d;
      s3_pos_q               <= s2_pos_q;
      s3_neg_q               <= s2_neg_q;
      s3_over_q              <= s2_over_q;
      s3_smag_q              <= 15'(prod >> RECIP_SHIFT);
      s4_pos_q               <= s3_pos_q;
      s4_neg_q               <= s3_neg_q;
      s4_over_q              <= s3_over_q;
      s4_therm_q             <= therm_d;
      out_q.bottom_angle     <= s4_pos_q.bottom;
      out_q.top_angle        <= top_d;
      out_q.rotator_angle    <= s4_pos_q.rotator;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/two_link_arm_sweep_with_height_hold_unit.sv =====
// ----------------------------------------------------------------------------
// Two-link arm sweep with height hold
// Sweeps the bottom and rotator joints and solves the top joint for height.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one millisecond time stamp per item. When interval_ms has
//   gone by since the last step, the bottom and rotator angles advance one
//   degree and the top angle is solved so the tip holds target_height.
//   out_ch carries bottom, top and rotator angles; a step with no solution
//   advances the sweep but gives no item, and items that are not due give
//   nothing either.
//   One item is accepted per cycle while the step queue has room. A result
//   passes through the step queue, the four solver pipe stages (numerator,
//   magnitude, divide by ten, arcsine thresholds) and the output register.
//   When out_ch stalls the solver pipe holds; the four-entry step queue keeps
//   taking time items until it is full, then in_ch.ready drops.
//   Reset is asynchronous and active low; it restores the sweep start
//   positions and the register defaults, with no clearing pass.
//   Registers are written through cfg_we_i, cfg_idx_i and cfg_data_i while
//   the block is idle: index 0 is target_height, index 1 is interval_ms.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module two_link_arm_sweep_with_height_hold_unit import tlas_pkg::*; #(
  parameter int unsigned HEIGHT_FRAC_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tlas_stream_if.sink           in_ch,
  tlas_stream_if.source         out_ch,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [12:0] height_q;
  logic [15:0] interval_q;
  in_item_t    in_item;
  out_item_t   out_item;
  logic        push;
  step_t       push_data;
  step_t       head;
  logic        pop;
  fifo_stat_t  fstat;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q   <= HEIGHT_RST;
      interval_q <= INTERVAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TARGET_HEIGHT: height_q   <= cfg_data_i[12:0];
        REG_INTERVAL:      interval_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_item = in_ch.data;

  tlas_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .now_ms_i    (in_item.now_ms),
    .in_ready_o  (in_ch.ready),
    .interval_i  (interval_q),
    .fifo_full_i (fstat.full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  tlas_fifo #(
    .DEPTH (4)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (fstat)
  );

  tlas_back #(
    .HEIGHT_FRAC_BITS (HEIGHT_FRAC_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .target_height_i (height_q),
    .head_valid_i    (~fstat.empty),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_ch.valid),
    .out_ready_i     (out_ch.ready),
    .out_data_o      (out_item)
  );

  assign out_ch.data = out_item;

  // The queue is never full and empty at once.
  `TLAS_ASSERT_ALWAYS(a_fifo_stat, clk_i, !(fstat.full && fstat.empty), "queue full and empty")
  // A result angle pair stays inside the sweep bands.
  `TLAS_ASSERT(a_bands, clk_i, rst_ni, out_ch.valid |-> (out_item.bottom_angle >= BOTTOM_MIN && out_item.bottom_angle <= BOTTOM_MAX && out_item.rotator_angle >= ROT_MIN && out_item.rotator_angle <= ROT_MAX), "angle out of sweep band")
  // The top angle respects both limits of the low band.
  `TLAS_ASSERT(a_low_band, clk_i, rst_ni, (out_ch.valid && out_item.bottom_angle <= BAND_SPLIT) |-> (9'(out_item.top_angle) + 9'(out_item.bottom_angle) >= ANGLE_MAX && 9'(out_item.top_angle) <= ANGLE_MAX), "top angle outside low band")
  // The top angle respects the limits of the high band.
  `TLAS_ASSERT(a_high_band, clk_i, rst_ni, (out_ch.valid && out_item.bottom_angle > BAND_SPLIT) |-> (9'(out_item.top_angle) >= BETA_FLOOR && 9'(out_item.top_angle) + 9'(out_item.bottom_angle) <= BAND_TOP), "top angle outside high band")

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Arm sweep testbench
// Drives millisecond time items into the sweep unit and checks every emitted
// pose against a predictor of the sweep, the height solver and the joint
// limits. Directed tests cover timing, wrap, zero and long intervals,
// unsolvable heights and reversals; random phases then vary both registers
// while the sender works in bursts and the receiver stalls on a mask pattern.
// ----------------------------------------------------------------------------
module tb_top;
  import tlas_pkg::*;

  localparam int     CLK_PERIOD   = 12;
  localparam int     RESET_CYCLES = 7;
  localparam int     HEIGHT_FRAC  = 8;
  localparam int     PIPE_TAIL    = 8;
  localparam int     DRAIN_CYCLES = 2000;
  localparam int     RUN_LIMIT    = 20000000;
  localparam int     SWEEP_ITEMS  = 210;
  localparam int     PHASE_STEPS  = 130;
  localparam int     NUM_PHASES   = 8;

  // Arm geometry and fixed point constants of the solver.
  localparam int     BOT_LO       = 70;
  localparam int     BOT_HI       = 170;
  localparam int     ROT_LO       = 40;
  localparam int     ROT_HI       = 140;
  localparam int     PIVOT_DEG    = 135;
  localparam int     TOP_LIMIT    = 180;
  localparam int     TOP_FLOOR    = 40;
  localparam int     BAND_SUM     = 310;
  localparam int     THETA_BASE   = 195;
  localparam int     OFFSET_Q14   = 106496;
  localparam int     UNIT_Q14     = 16384;
  localparam longint unsigned ARC_PI_Q30 = 64'd3373259426;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  tlas_stream_if #(.T(in_item_t))  in_ch ();
  tlas_stream_if #(.T(out_item_t)) out_ch ();

  two_link_arm_sweep_with_height_hold_unit #(
    .HEIGHT_FRAC_BITS(HEIGHT_FRAC)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predicted registers and sweep state.
  logic [12:0] height_q;
  logic [15:0] interval_q;
  logic [31:0] last_step_ms;
  logic [7:0]  bottom_deg;
  logic [7:0]  top_deg;
  logic [7:0]  rotator_deg;
  bit          bottom_down;
  bit          rotator_down;

  int unsigned sine_q14 [0:180];
  out_item_t   pose_q [$];
  int          error_count;
  int unsigned sweep_steps;
  int unsigned burst_left;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Sine of half degree steps in Q14, summed from a Q30 Taylor series.
  function automatic int unsigned taylor_sine_q14(int unsigned half_deg);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned term;
    longint          acc;
    ang    = (64'(half_deg) * ARC_PI_Q30 + 64'd180) / 64'd360;
    ang_sq = (ang * ang) >> 30;
    term   = ang;
    acc    = longint'(ang);
    for (int n = 1; n <= 7; n++) begin
      term = (term * ang_sq) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) acc = 0;
    return 32'((acc + 64'sd32768) >> 16);
  endfunction

  // Signed sine of a whole degree, folded by quadrant.
  function automatic int sine_of_deg(int d);
    int r;
    r = ((d % 360) + 360) % 360;
    if (r <= 90) return int'(sine_q14[2 * r]);
    if (r <= 180) return int'(sine_q14[2 * (180 - r)]);
    if (r <= 270) return -int'(sine_q14[2 * (r - 180)]);
    return -int'(sine_q14[2 * (360 - r)]);
  endfunction

  // Sweep state after reset, registers at their defaults.
  function automatic void reset_arm();
    height_q     = 13'd1280;
    interval_q   = 16'd50;
    last_step_ms = '0;
    bottom_deg   = 8'd90;
    top_deg      = 8'd120;
    rotator_deg  = 8'd90;
    bottom_down  = 1'b0;
    rotator_down = 1'b0;
  endfunction

  // One time item: step the sweep when due and solve the top joint.
  function automatic void step_arm(input logic [31:0] now, output bit solved,
                                   output out_item_t pose);
    logic [31:0] elapsed;
    int          a;
    int          num;
    int          mag;
    int          quot;
    int          deg;
    int          beta;
    int          lo;
    int          hi;
    solved  = 1'b0;
    pose    = '0;
    elapsed = now - last_step_ms;
    if (elapsed < 32'(interval_q)) return;
    sweep_steps++;
    last_step_ms = now;
    bottom_deg   = bottom_down ? bottom_deg - 8'd1 : bottom_deg + 8'd1;
    rotator_deg  = rotator_down ? rotator_deg - 8'd1 : rotator_deg + 8'd1;
    if (bottom_deg >= BOT_HI || bottom_deg <= BOT_LO) bottom_down = !bottom_down;
    if (rotator_deg >= ROT_HI || rotator_deg <= ROT_LO) rotator_down = !rotator_down;

    // Height error over the top link length, rounded half away from zero.
    a    = int'(bottom_deg);
    num  = (int'(height_q) <<< (14 - HEIGHT_FRAC)) - OFFSET_Q14
         - 8 * sine_of_deg(THETA_BASE - a);
    mag  = (num < 0) ? -num : num;
    quot = (mag + 5) / 10;
    if (quot > UNIT_Q14) return;

    // Arcsine rounded to whole degrees by counting crossed thresholds.
    deg = 0;
    for (int k = 1; k <= 90; k++) begin
      if (quot >= int'(sine_q14[2 * k - 1])) deg++;
    end
    beta = (num < 0) ? PIVOT_DEG - deg : PIVOT_DEG + deg;

    // The allowed band of the top joint depends on the bottom angle.
    if (a <= PIVOT_DEG) begin
      lo = TOP_LIMIT - a;
      hi = TOP_LIMIT;
    end else begin
      lo = TOP_FLOOR;
      hi = BAND_SUM - a;
    end
    if (beta < lo) begin
      beta = lo;
    end else if (beta > hi) begin
      beta = hi;
    end
    top_deg            = 8'(beta);
    solved             = 1'b1;
    pose.bottom_angle  = bottom_deg;
    pose.top_angle     = top_deg;
    pose.rotator_angle = rotator_deg;
  endfunction

  // Present one time item and wait until it is taken; valid stays high.
  task automatic send_time(input logic [31:0] now);
    bit        solved;
    out_item_t pose;
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{now_ms: now};
    do @(posedge clk_i); while (!in_ch.ready);
    step_arm(now, solved, pose);
    if (solved) pose_q.push_back(pose);
  endtask

  task automatic idle_gap(input int unsigned cycles);
    if (cycles > 0) begin
      in_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Bursts of random length, with gaps unless the phase runs steady.
  task automatic pace_sender(input bit steady);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady) idle_gap($urandom_range(1, 6));
    end
    burst_left--;
  endtask

  // Stop sending and wait for every expected pose, then for the pipe tail.
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (pose_q.size() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk_i);
      waited++;
    end
    if (pose_q.size() != 0) begin
      $error("%0d expected result items never arrived", pose_q.size());
      error_count++;
      pose_q.delete();
    end
    repeat (PIPE_TAIL) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_TARGET_HEIGHT: height_q = value[12:0];
      default:           interval_q = value;
    endcase
  endtask

  // Mostly due items, some early ones, random elapsed times and pure noise.
  function automatic logic [31:0] pick_time();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return last_step_ms + 32'(interval_q) + $urandom_range(0, 3);
    if (roll < 85) begin
      return last_step_ms + ((interval_q == 0) ? 32'd0 : $urandom_range(0, interval_q - 1));
    end
    if (roll < 95) return last_step_ms + $urandom;
    return $urandom;
  endfunction

  // Due and not yet due items at the default interval, across the time wrap.
  task automatic test_step_timing();
    send_time(32'd0);
    send_time(32'd49);
    send_time(32'd50);
    send_time(32'd99);
    send_time(32'd100);
    send_time(32'hFFFF_FFFF);
    send_time(32'h0000_0030);
    send_time(32'h0000_0031);
    drain_results();
  endtask

  // A zero interval steps on every item, even a repeated time.
  task automatic test_zero_interval();
    write_reg(REG_INTERVAL, 16'd0);
    send_time(last_step_ms);
    send_time(last_step_ms);
    send_time(32'h1234_5678);
    drain_results();
  endtask

  // Heights out of reach still advance the sweep without a result.
  task automatic test_no_solution();
    write_reg(REG_TARGET_HEIGHT, 16'd8191);
    write_reg(REG_INTERVAL, 16'd1);
    send_time(last_step_ms + 32'd1);
    send_time(last_step_ms);
    send_time(last_step_ms + 32'd2);
    drain_results();
    write_reg(REG_TARGET_HEIGHT, 16'd0);
    send_time(last_step_ms + 32'd1);
    send_time(last_step_ms + 32'd2);
    drain_results();
  endtask

  // The longest interval, one millisecond short and then exactly due.
  task automatic test_long_interval();
    write_reg(REG_TARGET_HEIGHT, 16'd1280);
    write_reg(REG_INTERVAL, 16'd65535);
    send_time(last_step_ms + 32'd65534);
    send_time(last_step_ms + 32'd65535);
    drain_results();
  endtask

  // Enough steps to turn both joints at both ends of their sweep.
  task automatic test_sweep_reversal();
    write_reg(REG_INTERVAL, 16'd0);
    write_reg(REG_TARGET_HEIGHT, 16'd3000);
    repeat (SWEEP_ITEMS) begin
      send_time($urandom);
      pace_sender(1'b0);
    end
    drain_results();
  endtask

  // Phases with fresh register settings; idle between them for the writes.
  task automatic test_random_phases();
    int unsigned phase_end;
    logic [12:0] height;
    logic [15:0] period;
    bit          steady;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          height = 13'd0;
          period = 16'd0;
        end
        1: begin
          height = 13'd8191;
          period = 16'd65535;
        end
        2: begin
          height = 13'($urandom_range(0, 5500));
          period = 16'd1;
        end
        3: begin
          height = 13'($urandom_range(0, 5500));
          period = 16'd50;
        end
        default: begin
          if ($urandom_range(0, 4) != 0) begin
            height = 13'($urandom_range(0, 5500));
          end else begin
            height = 13'($urandom_range(0, 8191));
          end
          period = 16'($urandom_range(1, 400));
        end
      endcase
      write_reg(REG_TARGET_HEIGHT, 16'(height));
      write_reg(REG_INTERVAL, period);
      steady    = (phase % 3 == 0);
      phase_end = sweep_steps + PHASE_STEPS;
      while (sweep_steps < phase_end) begin
        send_time(pick_time());
        pace_sender(steady);
      end
      drain_results();
    end
  endtask

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      error_count++;
    end
  endfunction

  // Compare each accepted pose with the oldest prediction.
  always @(posedge clk_i) begin : pose_check
    out_item_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pose_q.size() == 0) begin
        $error("unexpected result item: bottom %0d top %0d rotator %0d",
               out_ch.data.bottom_angle, out_ch.data.top_angle,
               out_ch.data.rotator_angle);
        error_count++;
      end else begin
        want = pose_q.pop_front();
        check_field("bottom_angle", want.bottom_angle, out_ch.data.bottom_angle);
        check_field("top_angle", want.top_angle, out_ch.data.top_angle);
        check_field("rotator_angle", want.rotator_angle, out_ch.data.rotator_angle);
      end
    end
  end

  // Receiver stalls on an eight-bit slot mask that changes every window;
  // an all-zero mask gives a stretch with no stalls.
  initial begin : sink_stall
    logic [7:0]  stall_mask;
    logic [2:0]  slot;
    int unsigned window;
    out_ch.ready <= 1'b0;
    slot = '0;
    forever begin
      stall_mask = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
      window     = $urandom_range(16, 96);
      repeat (window) begin
        @(posedge clk_i);
        out_ch.ready <= !stall_mask[slot];
        slot++;
      end
    end
  end

  initial begin : run_limit
    #(RUN_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_data_i  <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    error_count = 0;
    sweep_steps = 0;
    burst_left  = 0;
    for (int i = 0; i <= 180; i++) sine_q14[i] = taylor_sine_q14(i);
    reset_arm();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_step_timing();
    test_zero_interval();
    test_no_solution();
    test_long_interval();
    test_sweep_reversal();
    test_random_phases();

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
